>>> rtl/core/ckx_pkg.sv
// Shared types, constants and fixed-point helpers for the chaotic keystream cipher.
// No dependencies; used by every module of the core.
`default_nettype none

package ckx_pkg;

    localparam int STATE_W = 32;
    localparam int FRAC_W  = 20;
    localparam int PROD_W  = 2 * STATE_W;
    localparam int SCL_W   = PROD_W - FRAC_W;

    typedef logic signed [STATE_W-1:0] state_t;
    typedef logic signed [PROD_W-1:0]  prod_t;

    localparam state_t STATE_MAX = {1'b0, {(STATE_W-1){1'b1}}};
    localparam state_t STATE_MIN = {1'b1, {(STATE_W-1){1'b0}}};

    // Euler constants, 20 fraction bits
    localparam state_t K_T  = 32'sd1049;
    localparam state_t K_TB = 32'sd15729;
    localparam state_t K_TG = 32'sd10486;
    localparam state_t K_A  = -32'sd1174405;

    localparam state_t SEED_RESET = 32'sd104858;

    // key bit extraction shifts (FRAC_W minus scale exponent)
    localparam int KX_SH = FRAC_W - 11;
    localparam int KY_SH = FRAC_W - 10;
    localparam int KZ_SH = FRAC_W - 12;
    localparam int KW_SH = FRAC_W - 10;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_Z = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_W = 2'd3;

    localparam logic CMD_SEED = 1'b0;
    localparam logic CMD_DATA = 1'b1;

    // step schedule on the shared multiplier
    localparam int PH_W = 3;
    localparam logic [PH_W-1:0] PH_WW     = 3'd0;
    localparam logic [PH_W-1:0] PH_TBZ    = 3'd1;
    localparam logic [PH_W-1:0] PH_CY     = 3'd2;
    localparam logic [PH_W-1:0] PH_TY     = 3'd3;
    localparam logic [PH_W-1:0] PH_TGI    = 3'd4;
    localparam logic [PH_W-1:0] PH_TYZX   = 3'd5;
    localparam logic [PH_W-1:0] PH_COMMIT = 3'd6;

    typedef struct packed {
        logic       command;
        logic [7:0] data_in;
    } in_item_t;

    typedef struct packed {
        logic [7:0] data_out;
        logic [7:0] key_byte;
    } out_item_t;

    typedef struct packed {
        logic            load_seed;
        logic            capture;
        logic            step;
        logic [PH_W-1:0] phase;
        logic            out_load;
    } ckx_cmd_t;

    function automatic state_t sat_add(input state_t a, input state_t b);
        logic signed [STATE_W:0] s;
        begin
            s = {a[STATE_W-1], a} + {b[STATE_W-1], b};
            if (s[STATE_W] != s[STATE_W-1])
                return s[STATE_W] ? STATE_MIN : STATE_MAX;
            return s[STATE_W-1:0];
        end
    endfunction

    function automatic state_t sat_sub(input state_t a, input state_t b);
        logic signed [STATE_W:0] s;
        begin
            s = {a[STATE_W-1], a} - {b[STATE_W-1], b};
            if (s[STATE_W] != s[STATE_W-1])
                return s[STATE_W] ? STATE_MIN : STATE_MAX;
            return s[STATE_W-1:0];
        end
    endfunction

    // floor(p / 2^FRAC_W), saturated to the state range
    function automatic state_t mul_scale(input prod_t p);
        logic [SCL_W-1:0] q;
        begin
            q = p[PROD_W-1:FRAC_W];
            if ((q[SCL_W-1:STATE_W-1] != '0) && (q[SCL_W-1:STATE_W-1] != '1))
                return q[SCL_W-1] ? STATE_MIN : STATE_MAX;
            return q[STATE_W-1:0];
        end
    endfunction

    // low two bits of v scaled and truncated toward zero
    function automatic logic [1:0] key_bits(input state_t v, input int unsigned sh);
        logic [STATE_W-1:0] uv;
        logic [STATE_W-1:0] m;
        logic [STATE_W-1:0] q;
        begin
            uv = v;
            m  = uv[STATE_W-1] ? (~uv + 1'b1) : uv;
            q  = m >> sh;
            if (uv[STATE_W-1])
                q = ~q + 1'b1;
            return q[1:0];
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/chaotic_keystream_xor_cipher_core.sv
// Top level of the chaotic keystream XOR cipher core.
// Depends on ckx_pkg, ckx_ctrl and ckx_datapath.
//
// Input channel (in_valid/in_stall/in_data): command 0 loads x, y, z, w from the
// init registers and runs WARMUP_STEPS Euler steps with no result; command 1 runs
// one step and returns data_in XOR key_byte on the output channel.
// Each Euler step runs the phases PH_WW, PH_TBZ, PH_CY, PH_TY, PH_TGI, PH_TYZX and
// PH_COMMIT, one product per phase before the commit on the single shared 32x32
// multiplier. out_valid rises once the step commits and the S_EMIT state loads the
// result register; the next item can be taken as soon as the result is loaded.
// A seed keeps the input stalled while its WARMUP_STEPS warm-up steps run.
// Output channel (out_valid/out_stall/out_data) is a register: a new item is
// accepted while a result waits; a finished step waits there only if the previous
// result is still stalled.
// Config port: cfg_we writes cfg_data to register cfg_index (0..3 = init x,y,z,w)
// at once; write only while idle.
// Reset clears x, y, z, w to zero, sets the init registers to about 0.1 and drops
// out_valid; data sent before any seed gives key byte 0.
`default_nettype none

module chaotic_keystream_xor_cipher_core #(
    parameter int WARMUP_STEPS = 5000
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire ckx_pkg::in_item_t             in_data,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output ckx_pkg::out_item_t                 out_data,
    input  wire logic                          cfg_we,
    input  wire logic [ckx_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ckx_pkg::STATE_W-1:0]   cfg_data
);

    ckx_pkg::ckx_cmd_t cmd;

    ckx_ctrl #(
        .WARMUP_STEPS (WARMUP_STEPS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_command (in_data.command),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .cmd        (cmd)
    );

    ckx_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .data_in   (in_data.data_in),
        .cmd       (cmd),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

>>> rtl/core/ckx_ctrl.sv
// Sequencer for the cipher core: input handshake, step phases, warm-up count, result valid.
// Depends on ckx_pkg; drives ckx_datapath through ckx_cmd_t.
`default_nettype none

module ckx_ctrl #(
    parameter int WARMUP_STEPS = 5000
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic              in_command,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output ckx_pkg::ckx_cmd_t      cmd
);

    localparam int CNT_W = (WARMUP_STEPS > 1) ? $clog2(WARMUP_STEPS + 1) : 1;
    localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(WARMUP_STEPS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_STEP = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]               state_reg, state_next;
    logic [ckx_pkg::PH_W-1:0] phase_reg, phase_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     seed_reg, seed_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     accept;
    logic                     slot_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        seed_next      = seed_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        cmd.phase      = phase_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    phase_next = ckx_pkg::PH_WW;
                    if (in_command == ckx_pkg::CMD_SEED)
                    begin
                        cmd.load_seed = 1'b1;
                        seed_next     = 1'b1;
                        cnt_next      = CNT_LOAD;
                        if (WARMUP_STEPS != 0)
                            state_next = S_STEP;
                    end
                    else
                    begin
                        cmd.capture = 1'b1;
                        seed_next   = 1'b0;
                        state_next  = S_STEP;
                    end
                end
            end
            S_STEP:
            begin
                cmd.step = 1'b1;
                if (phase_reg == ckx_pkg::PH_COMMIT)
                begin
                    phase_next = ckx_pkg::PH_WW;
                    if (!seed_reg)
                        state_next = S_EMIT;
                    else
                    begin
                        cnt_next = cnt_reg - 1'b1;
                        if (cnt_reg == CNT_W'(1))
                            state_next = S_IDLE;
                    end
                end
                else
                    phase_next = phase_reg + 1'b1;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= ckx_pkg::PH_WW;
            cnt_reg       <= '0;
            seed_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            seed_reg      <= seed_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/ckx_datapath.sv
// Datapath: seed registers, x/y/z/w state, one shared 32x32 multiplier, key and result register.
// Depends on ckx_pkg; sequenced by ckx_ctrl.
`default_nettype none

module ckx_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [ckx_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [ckx_pkg::STATE_W-1:0]       cfg_data,
    input  wire logic [7:0]                        data_in,
    input  wire ckx_pkg::ckx_cmd_t                 cmd,
    output ckx_pkg::out_item_t                     out_data
);

    ckx_pkg::state_t init_x_reg, init_y_reg, init_z_reg, init_w_reg;
    ckx_pkg::state_t x_reg, y_reg, z_reg, w_reg;
    ckx_pkg::state_t x_next, y_next, z_next, w_next;
    ckx_pkg::state_t coef_reg, zy_reg, yz_reg, inner_reg, nx_reg, ny_reg, nw_reg;
    ckx_pkg::prod_t  prod_reg, prod_next;
    ckx_pkg::state_t mul_a, mul_b, q;
    logic [7:0]      byte_reg;
    logic [7:0]      key;
    ckx_pkg::out_item_t out_reg;

    assign q = ckx_pkg::mul_scale(prod_reg);

    always_comb
    begin
        unique case (cmd.phase)
            ckx_pkg::PH_WW:   begin mul_a = w_reg;         mul_b = w_reg;     end
            ckx_pkg::PH_TBZ:  begin mul_a = ckx_pkg::K_TB; mul_b = z_reg;     end
            ckx_pkg::PH_CY:   begin mul_a = coef_reg;      mul_b = y_reg;     end
            ckx_pkg::PH_TY:   begin mul_a = ckx_pkg::K_T;  mul_b = y_reg;     end
            ckx_pkg::PH_TGI:  begin mul_a = ckx_pkg::K_TG; mul_b = inner_reg; end
            ckx_pkg::PH_TYZX: begin mul_a = ckx_pkg::K_T;  mul_b = yz_reg;    end
            default:          begin mul_a = w_reg;         mul_b = w_reg;     end
        endcase
        prod_next = mul_a * mul_b;
    end

    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        w_next = w_reg;
        if (cmd.load_seed)
        begin
            x_next = init_x_reg;
            y_next = init_y_reg;
            z_next = init_z_reg;
            w_next = init_w_reg;
        end
        else if (cmd.step && (cmd.phase == ckx_pkg::PH_COMMIT))
        begin
            x_next = nx_reg;
            y_next = ny_reg;
            z_next = ckx_pkg::sat_add(z_reg, q);
            w_next = nw_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_x_reg <= ckx_pkg::SEED_RESET;
            init_y_reg <= ckx_pkg::SEED_RESET;
            init_z_reg <= ckx_pkg::SEED_RESET;
            init_w_reg <= ckx_pkg::SEED_RESET;
            x_reg      <= '0;
            y_reg      <= '0;
            z_reg      <= '0;
            w_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    ckx_pkg::REG_INIT_X: init_x_reg <= cfg_data;
                    ckx_pkg::REG_INIT_Y: init_y_reg <= cfg_data;
                    ckx_pkg::REG_INIT_Z: init_z_reg <= cfg_data;
                    ckx_pkg::REG_INIT_W: init_w_reg <= cfg_data;
                    default: ;
                endcase
            end
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
            w_reg <= w_next;
        end
    end

    // step temporaries, one multiply issued per phase
    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            prod_reg <= prod_next;
            unique case (cmd.phase)
                ckx_pkg::PH_WW: ;
                ckx_pkg::PH_TBZ:
                begin
                    coef_reg <= ckx_pkg::sat_add(ckx_pkg::K_A, q);
                    zy_reg   <= ckx_pkg::sat_sub(z_reg, y_reg);
                end
                ckx_pkg::PH_CY:
                begin
                    nx_reg <= ckx_pkg::sat_add(x_reg, q);
                    yz_reg <= ckx_pkg::sat_sub(y_reg, z_reg);
                end
                ckx_pkg::PH_TY:
                begin
                    inner_reg <= ckx_pkg::sat_sub(zy_reg, q);
                    yz_reg    <= ckx_pkg::sat_sub(yz_reg, x_reg);
                end
                ckx_pkg::PH_TGI:  nw_reg <= ckx_pkg::sat_add(w_reg, q);
                ckx_pkg::PH_TYZX: ny_reg <= ckx_pkg::sat_add(y_reg, q);
                default: ;
            endcase
        end
        if (cmd.capture)
            byte_reg <= data_in;
        if (cmd.out_load)
        begin
            out_reg.key_byte <= key;
            out_reg.data_out <= byte_reg ^ key;
        end
    end

    assign key = {ckx_pkg::key_bits(x_reg, ckx_pkg::KX_SH),
                  ckx_pkg::key_bits(y_reg, ckx_pkg::KY_SH),
                  ckx_pkg::key_bits(z_reg, ckx_pkg::KZ_SH),
                  ckx_pkg::key_bits(w_reg, ckx_pkg::KW_SH)};

    assign out_data = out_reg;

endmodule

`default_nettype wire

>>> rtl/core/ckx_checker.sv
// Port-level checks for the cipher core, bound to the top level.
// Depends on ckx_pkg.
`default_nettype none

module ckx_checker #(
    parameter int WARMUP_STEPS = 5000
) (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_stall,
    input wire ckx_pkg::in_item_t  in_data,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire ckx_pkg::out_item_t out_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // an accepted data item, or a seed with warm-up steps, keeps the input stalled through its step
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (in_data.command || (WARMUP_STEPS != 0))
        |=> in_stall ##1 in_stall ##1 in_stall ##1 in_stall ##1 in_stall
            ##1 in_stall ##1 in_stall)
        else $error("input taken during a step");

    // a result only follows work on a data item
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without a step");

    // no result can appear straight from idle
    a_no_idle_result: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && !in_stall |=> !out_valid)
        else $error("result appeared from idle");

endmodule

bind chaotic_keystream_xor_cipher_core ckx_checker #(
    .WARMUP_STEPS (WARMUP_STEPS)
) u_ckx_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire

>>> tb/sv/tb.sv
// Self-checking testbench for chaotic_keystream_xor_cipher_core: seeds, warm-up and
// keystream bytes are predicted by a fixed-point Euler model held in the bench.
// Depends on ckx_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb;

    localparam int WARMUP       = 5000;
    localparam int SEED_CYCLES  = 7 * WARMUP + 30;
    localparam int QUIET_LIMIT  = 8 * 7 * WARMUP;
    localparam int N_PHASES     = 8;
    localparam int PHASE_ITEMS  = 240;
    localparam int LONG_HOLD    = 400;
    localparam longint FX_HI    = 64'sd2147483647;
    localparam longint FX_LO    = -64'sd2147483648;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;
    typedef enum int {SM_FULL, SM_SMALL, SM_EXTREME, SM_NEAR} seed_mode_e;

    typedef struct packed {
        row_kind_e  kind;
        logic       command;
        logic [7:0] data_in;
        logic       typed;
        logic [7:0] want_out;
        logic [7:0] want_key;
        logic [1:0] cfg_sel;
    } script_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    ckx_pkg::in_item_t  in_data = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    ckx_pkg::out_item_t out_data;
    logic                          cfg_we = 1'b0;
    logic [ckx_pkg::CFG_IDX_W-1:0] cfg_index = ckx_pkg::REG_INIT_X;
    logic [ckx_pkg::STATE_W-1:0]   cfg_data = '0;

    // predictor state
    ckx_pkg::state_t orbit_x = '0, orbit_y = '0, orbit_z = '0, orbit_w = '0;
    ckx_pkg::state_t seed_regs [4] = '{ckx_pkg::SEED_RESET, ckx_pkg::SEED_RESET,
                                       ckx_pkg::SEED_RESET, ckx_pkg::SEED_RESET};
    bit     warmup_pending = 1'b0;

    ckx_pkg::out_item_t pending_bytes [$];
    int                 fail_count = 0;
    int                 results_seen = 0;
    int unsigned        quiet_cycles = 0;

    logic [ckx_pkg::CFG_IDX_W-1:0] reg_ids [4] = '{ckx_pkg::REG_INIT_X, ckx_pkg::REG_INIT_Y,
                                                   ckx_pkg::REG_INIT_Z, ckx_pkg::REG_INIT_W};

    ckx_pkg::state_t corner_cfg [4][4] = '{
        '{32'sd0, 32'sd0, 32'sd0, 32'sd0},
        '{ckx_pkg::STATE_MAX, ckx_pkg::STATE_MAX, ckx_pkg::STATE_MAX, ckx_pkg::STATE_MAX},
        '{ckx_pkg::STATE_MIN, ckx_pkg::STATE_MIN, ckx_pkg::STATE_MIN, ckx_pkg::STATE_MIN},
        '{ckx_pkg::STATE_MAX, ckx_pkg::STATE_MIN, 32'sd0, -32'sd1}
    };

    localparam int N_ROWS = 23;
    script_row_t script [N_ROWS] = '{
        '{ROW_ITEM, ckx_pkg::CMD_DATA, 8'h00, 1'b1, 8'h00, 8'h00, 2'd0},
        '{ROW_ITEM, ckx_pkg::CMD_DATA, 8'hFF, 1'b1, 8'hFF, 8'h00, 2'd0},
        '{ROW_ITEM, ckx_pkg::CMD_DATA, 8'h3C, 1'b1, 8'h3C, 8'h00, 2'd0},
        '{ROW_ITEM, ckx_pkg::CMD_SEED, 8'hFF, 1'b0, 8'h00, 8'h00, 2'd0},
        '{ROW_ITEM, ckx_pkg::CMD_DATA, 8'h00, 1'b0, 8'h00, 8'h00, 2'd0},
        '{ROW_ITEM, ckx_pkg::CMD_DATA, 8'hFF, 1'b0, 8'h00, 8'h00, 2'd0},
        '{ROW_ITEM, ckx_pkg::CMD_DATA, 8'h96, 1'b0, 8'h00, 8'h00, 2'd0},
        '{ROW_CFG,  ckx_pkg::CMD_SEED, 8'h00, 1'b0, 8'h00, 8'h00, 2'd0},
        '{ROW_ITEM, ckx_pkg::CMD_SEED, 8'h00, 1'b0, 8'h00, 8'h00, 2'd0},
        '{ROW_ITEM, ckx_pkg::CMD_DATA, 8'h00, 1'b1, 8'h00, 8'h00, 2'd0},
        '{ROW_ITEM, ckx_pkg::CMD_DATA, 8'hFF, 1'b1, 8'hFF, 8'h00, 2'd0},
        '{ROW_CFG,  ckx_pkg::CMD_SEED, 8'h00, 1'b0, 8'h00, 8'h00, 2'd1},
        '{ROW_ITEM, ckx_pkg::CMD_SEED, 8'h55, 1'b0, 8'h00, 8'h00, 2'd0},
        '{ROW_ITEM, ckx_pkg::CMD_DATA, 8'h00, 1'b0, 8'h00, 8'h00, 2'd0},
        '{ROW_ITEM, ckx_pkg::CMD_DATA, 8'hFF, 1'b0, 8'h00, 8'h00, 2'd0},
        '{ROW_CFG,  ckx_pkg::CMD_SEED, 8'h00, 1'b0, 8'h00, 8'h00, 2'd2},
        '{ROW_ITEM, ckx_pkg::CMD_SEED, 8'hAA, 1'b0, 8'h00, 8'h00, 2'd0},
        '{ROW_ITEM, ckx_pkg::CMD_DATA, 8'h00, 1'b0, 8'h00, 8'h00, 2'd0},
        '{ROW_ITEM, ckx_pkg::CMD_DATA, 8'hFF, 1'b0, 8'h00, 8'h00, 2'd0},
        '{ROW_CFG,  ckx_pkg::CMD_SEED, 8'h00, 1'b0, 8'h00, 8'h00, 2'd3},
        '{ROW_ITEM, ckx_pkg::CMD_SEED, 8'h00, 1'b0, 8'h00, 8'h00, 2'd0},
        '{ROW_ITEM, ckx_pkg::CMD_DATA, 8'h00, 1'b0, 8'h00, 8'h00, 2'd0},
        '{ROW_ITEM, ckx_pkg::CMD_DATA, 8'h81, 1'b0, 8'h00, 8'h00, 2'd0}
    };

    chaotic_keystream_xor_cipher_core #(
        .WARMUP_STEPS(WARMUP)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic ckx_pkg::state_t fx_clamp(input longint v);
        if (v > FX_HI)
            return ckx_pkg::state_t'(FX_HI);
        if (v < FX_LO)
            return ckx_pkg::state_t'(FX_LO);
        return ckx_pkg::state_t'(v);
    endfunction

    function automatic ckx_pkg::state_t fx_add(input ckx_pkg::state_t a,
                                               input ckx_pkg::state_t b);
        return fx_clamp(longint'(a) + longint'(b));
    endfunction

    function automatic ckx_pkg::state_t fx_sub(input ckx_pkg::state_t a,
                                               input ckx_pkg::state_t b);
        return fx_clamp(longint'(a) - longint'(b));
    endfunction

    // product floored to FRAC_W fraction bits
    function automatic ckx_pkg::state_t fx_mul(input ckx_pkg::state_t a,
                                               input ckx_pkg::state_t b);
        longint p;
        p = longint'(a) * longint'(b);
        return fx_clamp(p >>> ckx_pkg::FRAC_W);
    endfunction

    function automatic logic [1:0] scaled_pair(input ckx_pkg::state_t v, input int sh);
        longint m;
        m = (v < 0) ? -longint'(v) : longint'(v);
        m = m >>> sh;
        if (v < 0)
            m = -m;
        return m[1:0];
    endfunction

    task automatic euler_advance();
        ckx_pkg::state_t nx, ny, nz, nw, coef, inner;
        nx    = fx_add(orbit_x, fx_mul(ckx_pkg::K_TB, orbit_z));
        coef  = fx_add(ckx_pkg::K_A, fx_mul(orbit_w, orbit_w));
        inner = fx_sub(fx_sub(orbit_z, orbit_y), fx_mul(coef, orbit_y));
        ny    = fx_add(orbit_y, fx_mul(ckx_pkg::K_TG, inner));
        nz    = fx_add(orbit_z,
                       fx_mul(ckx_pkg::K_T, fx_sub(fx_sub(orbit_y, orbit_z), orbit_x)));
        nw    = fx_add(orbit_w, fx_mul(ckx_pkg::K_T, orbit_y));
        orbit_x = nx;
        orbit_y = ny;
        orbit_z = nz;
        orbit_w = nw;
    endtask

    task automatic predict_cipher(input ckx_pkg::in_item_t it,
                                  output ckx_pkg::out_item_t res);
        logic [7:0] key;
        euler_advance();
        key = {scaled_pair(orbit_x, ckx_pkg::KX_SH), scaled_pair(orbit_y, ckx_pkg::KY_SH),
               scaled_pair(orbit_z, ckx_pkg::KZ_SH), scaled_pair(orbit_w, ckx_pkg::KW_SH)};
        res.key_byte = key;
        res.data_out = it.data_in ^ key;
    endtask

    task automatic reseed_orbit();
        orbit_x = seed_regs[ckx_pkg::REG_INIT_X];
        orbit_y = seed_regs[ckx_pkg::REG_INIT_Y];
        orbit_z = seed_regs[ckx_pkg::REG_INIT_Z];
        orbit_w = seed_regs[ckx_pkg::REG_INIT_W];
        repeat (WARMUP) euler_advance();
    endtask

    function automatic int pick_wait(input bit burst);
        return burst ? 0 : $urandom_range(0, 5);
    endfunction

    function automatic ckx_pkg::state_t seed_value(input seed_mode_e mode);
        case (mode)
            SM_FULL:  return ckx_pkg::state_t'($urandom);
            SM_SMALL: return ckx_pkg::state_t'($urandom_range(0, 8388608)) - 32'sd4194304;
            SM_NEAR:  return ckx_pkg::SEED_RESET
                             + ckx_pkg::state_t'($urandom_range(0, 2047)) - 32'sd1024;
            default:
                case ($urandom_range(0, 4))
                    0:       return ckx_pkg::STATE_MAX;
                    1:       return ckx_pkg::STATE_MIN;
                    2:       return 32'sd0;
                    3:       return -32'sd1;
                    default: return 32'sd1;
                endcase
        endcase
    endfunction

    bit send_burst = 1'b0;

    // one input transfer; the predictor runs when the block takes it
    task automatic send_item(input ckx_pkg::in_item_t it, input bit typed,
                             input ckx_pkg::out_item_t typed_res);
        int gap;
        ckx_pkg::out_item_t res;
        if ($urandom_range(0, 39) == 0)
            send_burst = ~send_burst;
        gap = pick_wait(send_burst);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (in_stall);
        if (it.command == ckx_pkg::CMD_SEED)
        begin
            reseed_orbit();
            warmup_pending = 1'b1;
        end
        else
        begin
            predict_cipher(it, res);
            warmup_pending = 1'b0;
            pending_bytes.push_back(typed ? typed_res : res);
        end
    endtask

    task automatic drain_bytes();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_bytes.size() != 0) @(posedge clk);
    endtask

    // block idle: all bytes back, and a trailing warm-up given time to finish
    task automatic settle();
        drain_bytes();
        if (warmup_pending)
            repeat (SEED_CYCLES) @(posedge clk);
        else
            repeat (12) @(posedge clk);
        warmup_pending = 1'b0;
    endtask

    task automatic write_seeds(input ckx_pkg::state_t vals [4]);
        for (int r = 0; r < 4; r++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= reg_ids[r];
            cfg_data  <= vals[r];
            @(posedge clk);
            seed_regs[reg_ids[r]] = vals[r];
        end
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        ckx_pkg::in_item_t  it;
        ckx_pkg::out_item_t want;
        ckx_pkg::state_t    vals [4];
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            if (script[i].kind == ROW_CFG)
            begin
                settle();
                write_seeds(corner_cfg[script[i].cfg_sel]);
            end
            else
            begin
                it.command    = script[i].command;
                it.data_in    = script[i].data_in;
                want.data_out = script[i].want_out;
                want.key_byte = script[i].want_key;
                send_item(it, script[i].typed, want);
            end
        end

        for (int p = 0; p < N_PHASES; p++)
        begin
            settle();
            for (int r = 0; r < 4; r++)
                vals[r] = seed_value(seed_mode_e'(p % 4));
            write_seeds(vals);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                it.command = ckx_pkg::CMD_DATA;
                if ((n == 0 && (p == 0 || $urandom_range(0, 3) != 0)) || (p == 5 && n == 120))
                    it.command = ckx_pkg::CMD_SEED;
                it.data_in = 8'($urandom_range(0, 255));
                if (p == 2 && n == 100)
                    drain_bytes();
                send_item(it, 1'b0, '0);
            end
        end

        settle();
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // result side
    initial
    begin
        bit                 take_burst;
        int                 hold;
        ckx_pkg::out_item_t want;
        take_burst = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                take_burst = ~take_burst;
            hold = pick_wait(take_burst);
            if (results_seen == 300 || results_seen == 1200)
                hold = LONG_HOLD;
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            results_seen++;
            if (pending_bytes.size() == 0)
            begin
                $error("result with nothing pending: data_out %02h key_byte %02h",
                       out_data.data_out, out_data.key_byte);
                fail_count++;
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (out_data.data_out !== want.data_out)
                begin
                    $error("data_out: expected %02h, got %02h", want.data_out, out_data.data_out);
                    fail_count++;
                end
                if (out_data.key_byte !== want.key_byte)
                begin
                    $error("key_byte: expected %02h, got %02h", want.key_byte, out_data.key_byte);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule

>>> files.f
rtl/core/ckx_pkg.sv
rtl/core/ckx_ctrl.sv
rtl/core/ckx_datapath.sv
rtl/core/chaotic_keystream_xor_cipher_core.sv
rtl/core/ckx_checker.sv
tb/sv/tb.sv
